// ===== sv/apr_pkg.sv =====
// Shared constants, types and state codes for the aging page replacement block.
// Used by the frame cell and the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package apr_pkg;

  localparam int unsigned FRAMES    = 16;
  localparam int unsigned PAGE_BITS = 16;
  localparam int unsigned AGE_W     = 8;
  localparam int unsigned IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CNT_W     = $clog2(FRAMES + 1);
  localparam int unsigned CFG_W     = 5;

  localparam logic [AGE_W-1:0] AGE_TOP      = 8'd128;
  localparam logic [CFG_W-1:0] NF_RESET     = 5'd16;
  localparam logic             REG_NUM_FRAMES = 1'b0;

  // Search token handed from one frame cell to the next.
  typedef struct packed {
    logic                 vld;
    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;
    logic [AGE_W:0]       min_age;
    logic [IDX_W-1:0]     min_idx;
    logic [PAGE_BITS-1:0] min_page;
  } tok_t;

  // Context and update command broadcast to every cell.
  typedef struct packed {
    logic [PAGE_BITS-1:0] page;
    logic [CNT_W-1:0]     rc;
    logic [CNT_W-1:0]     nf;
    logic                 upd;
    logic                 miss;
    logic [IDX_W-1:0]     used;
    logic [CNT_W-1:0]     rc_new;
  } ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_UPDATE = 3'b100
  } state_e;

endpackage

`default_nettype wire

// ===== sv/apr_cell.sv =====
// One page frame: holds its page number and age counter, refines the search token.
// Depends on apr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module apr_cell (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [apr_pkg::IDX_W-1:0] idx_i,
  input  wire apr_pkg::ctl_t            ctl_i,
  input  wire apr_pkg::tok_t            tok_i,
  output apr_pkg::tok_t                 tok_o
);
  import apr_pkg::*;

  logic [PAGE_BITS-1:0] page_q;
  logic [AGE_W-1:0]     age_q;
  tok_t                 tok_d;
  tok_t                 tok_q;
  logic                 vld_q;
  logic                 resident;
  logic                 in_use;

  assign resident = CNT_W'(idx_i) < ctl_i.rc;
  assign in_use   = CNT_W'(idx_i) < ctl_i.nf;

  always_comb begin
    tok_d = tok_i;
    if (resident && !tok_i.hit && (page_q == ctl_i.page)) begin
      tok_d.hit     = 1'b1;
      tok_d.hit_idx = idx_i;
    end
    // Strict compare keeps the lowest index on equal ages.
    if (in_use && ({1'b0, age_q} < tok_i.min_age)) begin
      tok_d.min_age  = {1'b0, age_q};
      tok_d.min_idx  = idx_i;
      tok_d.min_page = page_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= tok_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    if (ctl_i.upd) begin
      if (idx_i == ctl_i.used) begin
        if (ctl_i.miss) begin
          page_q <= ctl_i.page;
          age_q  <= AGE_TOP;
        end else begin
          age_q <= {1'b1, age_q[AGE_W-1:1]};
        end
      end else if (CNT_W'(idx_i) < ctl_i.rc_new) begin
        age_q <= {1'b0, age_q[AGE_W-1:1]};
      end
    end
  end

  always_comb begin
    tok_o     = tok_q;
    tok_o.vld = vld_q;
  end

endmodule

`default_nettype wire

// ===== sv/aging_page_replacement.sv =====
// Top level of the aging page replacement block: control, registers and the cell row.
// Depends on apr_pkg and apr_cell.
`timescale 1ns / 1ps
`default_nettype none

// Each input word is one page reference. The block keeps up to num_frames resident
// pages in a row of FRAMES frame cells, each with an 8-bit age counter. A search token
// enters the first cell in the cycle after the word is accepted and moves one cell per
// cycle, picking up a hit and the oldest frame among the first num_frames frames on
// the way. The token leaving the last cell is captured, and the update state then
// writes the page into the chosen frame and ages every resident counter in parallel.
// The next word is taken only after the update of the current reference is done.
// The result word sits in an output register, so the next reference is accepted
// while it waits to be taken; a new result is only written once the previous one
// has left, and the update cycle is held until then. The restart flag empties the
// table and zeroes the fault count before its own reference is handled. num_frames
// sits at byte address 0 of the APB port; 0 acts as 1 and values above FRAMES act
// as FRAMES. Frame contents need no clearing after reset, as only frames below the
// resident count are ever matched.
module aging_page_replacement (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Reference stream.
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // [15:0] page
  input  wire logic        s_axis_tuser_i,   // [0] restart
  // Result stream.
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [55:0]      m_axis_tdata_o,   // [0] hit, [4:1] frame, [5] evicted,
                                             // [21:6] evicted_page, [53:22] fault_count
  // Configuration port.
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [2:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  output logic [31:0]      prdata_o,
  output logic             pready_o
);
  import apr_pkg::*;

  state_e               state_q;
  logic                 start_q;
  logic [CFG_W-1:0]     nf_cfg_q;
  logic [CNT_W-1:0]     rc_q;
  logic [CNT_W-1:0]     nf_q;
  logic [CNT_W-1:0]     nf_clamped;
  logic [PAGE_BITS-1:0] page_q;
  logic [31:0]          fault_q;
  tok_t                 srch_q;

  logic                 m_valid_q;
  logic                 res_hit_q;
  logic [3:0]           res_frame_q;
  logic                 res_evict_q;
  logic [15:0]          res_epage_q;
  logic [31:0]          res_fault_q;

  tok_t                 tok [FRAMES+1];
  ctl_t                 ctl;

  logic                 accept;
  logic                 out_free;
  logic                 do_update;
  logic                 append;
  logic                 evict;
  logic [IDX_W-1:0]     used;
  logic [CNT_W-1:0]     rc_new;
  logic [31:0]          fault_new;

  // The configuration register.
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == REG_NUM_FRAMES) ? {{(32-CFG_W){1'b0}}, nf_cfg_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nf_cfg_q <= NF_RESET;
    end else if (psel_i && penable_i && pwrite_i && pready_o &&
                 (paddr_i[2] == REG_NUM_FRAMES)) begin
      nf_cfg_q <= pwdata_i[CFG_W-1:0];
    end
  end

  // Out-of-range frame counts are folded into 1..FRAMES when a word is taken.
  always_comb begin
    if (nf_cfg_q == '0) begin
      nf_clamped = CNT_W'(1);
    end else if (32'(nf_cfg_q) > FRAMES) begin
      nf_clamped = CNT_W'(FRAMES);
    end else begin
      nf_clamped = CNT_W'(nf_cfg_q);
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign do_update       = (state_q == ST_UPDATE) && out_free;

  // Decision from the token that left the last cell. A miss fills the next free frame
  // while the resident count is below num_frames, and otherwise replaces the oldest frame.
  assign append = !srch_q.hit && (rc_q < nf_q);
  assign evict  = !srch_q.hit && !append;
  assign rc_new = append ? rc_q + CNT_W'(1) : rc_q;
  assign fault_new = (!srch_q.hit && (fault_q != '1)) ? fault_q + 32'd1 : fault_q;

  always_comb begin
    priority if (srch_q.hit) begin
      used = srch_q.hit_idx;
    end else if (append) begin
      used = IDX_W'(rc_q);
    end else begin
      used = srch_q.min_idx;
    end
  end

  always_comb begin
    ctl.page   = page_q;
    ctl.rc     = rc_q;
    ctl.nf     = nf_q;
    ctl.upd    = do_update;
    ctl.miss   = !srch_q.hit;
    ctl.used   = used;
    ctl.rc_new = rc_new;
  end

  // The token enters the first cell with no hit and an age above any counter.
  always_comb begin
    tok[0].vld      = start_q;
    tok[0].hit      = 1'b0;
    tok[0].hit_idx  = '0;
    tok[0].min_age  = {1'b1, {AGE_W{1'b0}}};
    tok[0].min_idx  = '0;
    tok[0].min_page = '0;
  end

  for (genvar k = 0; k < FRAMES; k++) begin : g_cell
    apr_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (IDX_W'(k)),
      .ctl_i  (ctl),
      .tok_i  (tok[k]),
      .tok_o  (tok[k+1])
    );
  end

  // Sequencer and table-wide counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      start_q   <= 1'b0;
      rc_q      <= '0;
      fault_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      start_q <= accept;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (s_axis_tuser_i) begin
              rc_q    <= '0;
              fault_q <= '0;
            end
            state_q <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (tok[FRAMES].vld) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (out_free) begin
            rc_q    <= rc_new;
            fault_q <= fault_new;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (do_update) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      page_q <= PAGE_BITS'(s_axis_tdata_i);
      nf_q   <= nf_clamped;
    end
    if ((state_q == ST_SEARCH) && tok[FRAMES].vld) begin
      srch_q <= tok[FRAMES];
    end
    if (do_update) begin
      res_hit_q   <= srch_q.hit;
      res_frame_q <= 4'(used);
      res_evict_q <= evict;
      res_epage_q <= evict ? 16'(srch_q.min_page) : 16'd0;
      res_fault_q <= fault_new;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {2'b00, res_fault_q, res_epage_q, res_evict_q, res_frame_q,
                            res_hit_q};

endmodule

`default_nettype wire
